// ----- rtl/core/sem_pkg.sv -----
// Shared types and constants for the scored entry max extractor.
// No dependencies; imported by sem_ctrl, sem_dp and the top level.
package sem_pkg;

  localparam int unsigned MoveW  = 16;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned EntryW = MoveW + ScoreW;

  // Lowest score that is ever stored; the most negative code is raised to it.
  localparam logic [ScoreW-1:0] ScoreMinCode = 32'h8000_0000;
  localparam logic [ScoreW-1:0] ScoreFloor   = 32'h8000_0001;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } sem_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_SWAP
  } sem_state_e;

  typedef enum logic [1:0] {
    RES_EMPTY,
    RES_OVF,
    RES_BEST
  } sem_res_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     push_wr;
    logic     clear;
    logic     scan_start;
    logic     scan_step;
    logic     read_last;
    logic     swap_write;
    logic     res_load;
    sem_res_e res_sel;
  } sem_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_last;
    logic out_free;
  } sem_sts_t;

  function automatic logic [ScoreW-1:0] sat_score(input logic [ScoreW-1:0] s);
    sat_score = (s == ScoreMinCode) ? ScoreFloor : s;
  endfunction

endpackage

// ----- rtl/core/sem_ctrl.sv -----
// Controller state machine of the scored entry max extractor.
// Depends on sem_pkg for the state, command and status types.
module sem_ctrl import sem_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  sem_sts_t   sts_i,
  output sem_ctl_t   ctl_o
);

  sem_state_e state_q, state_d;
  sem_cmd_e   cmd;

  assign cmd = sem_cmd_e'(cmd_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ctl_o      = '0;
    ctl_o.res_sel = RES_EMPTY;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          unique case (cmd)
            CMD_PUSH: begin
              ctl_o.res_load = 1'b1;
              if (sts_i.full) begin
                ctl_o.res_sel = RES_OVF;
              end else begin
                ctl_o.push_wr = 1'b1;
              end
            end
            CMD_POP: begin
              if (sts_i.empty) begin
                ctl_o.res_load = 1'b1;
              end else begin
                ctl_o.scan_start = 1'b1;
                state_d          = ST_SCAN;
              end
            end
            CMD_CLEAR: begin
              ctl_o.clear    = 1'b1;
              ctl_o.res_load = 1'b1;
            end
            default: begin
              ctl_o.res_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        ctl_o.scan_step = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        ctl_o.read_last = 1'b1;
        state_d         = ST_SWAP;
      end
      ST_SWAP: begin
        if (sts_i.out_free) begin
          ctl_o.swap_write = 1'b1;
          ctl_o.res_load   = 1'b1;
          ctl_o.res_sel    = RES_BEST;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/sem_dp.sv -----
// Datapath of the scored entry max extractor: entry memory, count, scan and result register.
// Depends on sem_pkg for the command, status and result types.
module sem_dp import sem_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sem_ctl_t                 ctl_i,
  output sem_sts_t                 sts_o,
  input  logic [MoveW-1:0]         entry_move_i,
  input  logic signed [ScoreW-1:0] entry_score_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     found_o,
  output logic [MoveW-1:0]         top_move_o,
  output logic signed [ScoreW-1:0] top_score_o,
  output logic                     overflow_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [EntryW-1:0] mem_q [CAPACITY];

  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   idx_q, cmp_idx_q, pick_q, last_idx, rd_addr, wr_addr;
  logic [EntryW-1:0] rd_q, best_q, wr_data;
  logic              rd_en, wr_en, cmp_vld_q, first_q;
  logic              out_valid_q, found_q, ovf_q;
  logic [MoveW-1:0]  res_move_q;
  logic [ScoreW-1:0] res_score_q;

  assign last_idx = IdxW'(count_q - CntW'(1));

  assign sts_o.full     = (count_q == CntW'(CAPACITY));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.idx_last = (idx_q == last_idx);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Single write port: push at the tail, or the tail entry moved into the picked slot.
  always_comb begin
    wr_en   = ctl_i.push_wr || ctl_i.swap_write;
    wr_addr = ctl_i.swap_write ? pick_q : count_q[IdxW-1:0];
    wr_data = ctl_i.swap_write ? rd_q : {entry_move_i, sat_score(entry_score_i)};
    rd_en   = ctl_i.scan_step || ctl_i.read_last;
    rd_addr = ctl_i.read_last ? last_idx : idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl_i.clear) begin
      count_d = '0;
    end else if (ctl_i.push_wr) begin
      count_d = count_q + CntW'(1);
    end else if (ctl_i.swap_write) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      cmp_vld_q <= ctl_i.scan_step;
      if (ctl_i.scan_start) begin
        idx_q   <= '0;
        first_q <= 1'b1;
      end else begin
        if (ctl_i.scan_step) begin
          idx_q <= idx_q + IdxW'(1);
        end
        if (cmp_vld_q) begin
          first_q <= 1'b0;
        end
      end
      if (ctl_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Compare stage: strict greater-than keeps the earliest slot on a tie.
  always_ff @(posedge clk_i) begin
    if (ctl_i.scan_step) begin
      cmp_idx_q <= idx_q;
    end
    if (cmp_vld_q && (first_q ||
        ($signed(rd_q[ScoreW-1:0]) > $signed(best_q[ScoreW-1:0])))) begin
      best_q <= rd_q;
      pick_q <= cmp_idx_q;
    end
    if (ctl_i.res_load) begin
      unique case (ctl_i.res_sel)
        RES_BEST: begin
          found_q     <= 1'b1;
          ovf_q       <= 1'b0;
          res_move_q  <= best_q[EntryW-1:ScoreW];
          res_score_q <= best_q[ScoreW-1:0];
        end
        RES_OVF: begin
          found_q     <= 1'b0;
          ovf_q       <= 1'b1;
          res_move_q  <= '0;
          res_score_q <= '0;
        end
        default: begin
          found_q     <= 1'b0;
          ovf_q       <= 1'b0;
          res_move_q  <= '0;
          res_score_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign overflow_o  = ovf_q;
  assign top_move_o  = res_move_q;
  assign top_score_o = $signed(res_score_q);

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");
  a_swap_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.swap_write |-> count_q != '0)
    else $error("swap on an empty table");
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.scan_step |-> CntW'(idx_q) < count_q)
    else $error("scan read beyond the valid entries");
  a_no_result_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.res_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before transfer");
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push_wr |=> count_q == $past(count_q) + CntW'(1))
    else $error("push did not advance the count");
`endif

endmodule

// ----- rtl/core/scored_entry_max_extractor.sv -----
// Top level of the scored entry max extractor: controller plus datapath.
// Depends on sem_pkg, sem_ctrl and sem_dp.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+--------------------------------------
//   in      | input     | in_valid_i / in_ready_o  | cmd_i, entry_move_i, entry_score_i
//   out     | output    | out_valid_o / out_ready_i| found_o, top_move_o, top_score_o,
//           |           |                          | overflow_o
//
// Push, clear, an empty pop and an unused command are done in the idle state; a new
// command is taken in the cycle after, as long as the result register is free.
// A pop on a table of N entries scans them with one read of the entry memory per
// cycle, then reads the tail entry, and in a last step moves it into the picked
// slot and loads the result, which waits until the result register is free.
// Reset clears the entry count and the control state; the memory needs no clearing.
// A stalled output holds its result; the input stalls while a pop is in progress
// and whenever the result register is still full.
module scored_entry_max_extractor import sem_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               cmd_i,
  input  logic [MoveW-1:0]         entry_move_i,
  input  logic signed [ScoreW-1:0] entry_score_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     found_o,
  output logic [MoveW-1:0]         top_move_o,
  output logic signed [ScoreW-1:0] top_score_o,
  output logic                     overflow_o
);

  // Command and status bundles between the controller and the datapath.
  sem_ctl_t ctl;
  sem_sts_t sts;

  // The controller sequences each command: single-cycle work in the idle state,
  // and the scan, tail read and swap steps for a pop.
  sem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // The datapath holds the entries, the count, the running maximum and the
  // result register that decouples the output transfer from the input side.
  sem_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .entry_move_i  (entry_move_i),
    .entry_score_i (entry_score_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .top_move_o    (top_move_o),
    .top_score_o   (top_score_o),
    .overflow_o    (overflow_o)
  );

endmodule

// ----- tb/sem_extract_checker.sv -----
// Checker for the scored entry max extractor: watches both channels,
// keeps its own copy of the entry table and compares every result. Depends on sem_pkg.
`timescale 1ns / 1ps

module sem_extract_checker import sem_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        cmd_i,
  input  logic [MoveW-1:0]  entry_move_i,
  input  logic [ScoreW-1:0] entry_score_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              found_i,
  input  logic [MoveW-1:0]  top_move_i,
  input  logic [ScoreW-1:0] top_score_i,
  input  logic              overflow_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       results_checked_o,
  output int unsigned       entries_popped_o,
  output int unsigned       pushes_dropped_o
);

  typedef struct packed {
    logic                     found;
    logic [MoveW-1:0]         move;
    logic signed [ScoreW-1:0] score;
    logic                     overflow;
  } cmd_result_t;

  cmd_result_t              owed_results[$];
  logic [MoveW-1:0]         move_tbl[CAPACITY];
  logic signed [ScoreW-1:0] score_tbl[CAPACITY];
  int unsigned              live_entries;

  // Updates the table copy for one command and returns the result it must give.
  function automatic cmd_result_t apply_command(input sem_cmd_e op,
                                                input logic [MoveW-1:0] mv,
                                                input logic [ScoreW-1:0] sc);
    cmd_result_t              res;
    int unsigned              pick;
    int unsigned              tail;
    logic signed [ScoreW-1:0] top_score;
    res = '0;
    case (op)
      CMD_PUSH: begin
        if (live_entries >= CAPACITY) begin
          res.overflow = 1'b1;
        end else begin
          move_tbl[live_entries]  = mv;
          score_tbl[live_entries] = (sc == ScoreMinCode) ? ScoreFloor : sc;
          live_entries++;
        end
      end
      CMD_POP: begin
        if (live_entries != 0) begin
          pick      = 0;
          top_score = score_tbl[0];
          // Strictly greater, so the earliest slot keeps a tie.
          for (int unsigned i = 1; i < live_entries; i++) begin
            if (score_tbl[i] > top_score) begin
              top_score = score_tbl[i];
              pick      = i;
            end
          end
          res.found       = 1'b1;
          res.move        = move_tbl[pick];
          res.score       = top_score;
          tail            = live_entries - 1;
          move_tbl[pick]  = move_tbl[tail];
          score_tbl[pick] = score_tbl[tail];
          live_entries    = tail;
        end
      end
      CMD_CLEAR: begin
        live_entries = 0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic note_fault(input string what, input cmd_result_t want,
                            input cmd_result_t seen);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t: %s: expected found=%0b move=%h score=%0d ovf=%0b,",
               $realtime, what, want.found, want.move, want.score, want.overflow);
      $display("  got found=%0b move=%h score=%0d ovf=%0b",
               seen.found, seen.move, seen.score, seen.overflow);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cmd_result_t seen;
    cmd_result_t want;
    if (!rst_ni) begin
      owed_results.delete();
      live_entries = 0;
      pending_o    = 0;
    end else begin
      // The result side is checked first: a command taken at this edge cannot
      // have produced the result that leaves at the same edge.
      if (out_valid_i && out_ready_i) begin
        seen = '{found_i, top_move_i, top_score_i, overflow_i};
        results_checked_o++;
        if (seen.found === 1'b1) entries_popped_o++;
        if (seen.overflow === 1'b1) pushes_dropped_o++;
        if (owed_results.size() == 0) begin
          note_fault("result with nothing outstanding", '0, seen);
        end else begin
          want = owed_results.pop_front();
          if (seen.found !== want.found || seen.move !== want.move ||
              seen.score !== want.score || seen.overflow !== want.overflow) begin
            note_fault("result mismatch", want, seen);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = apply_command(sem_cmd_e'(cmd_i), entry_move_i, entry_score_i);
        owed_results.insert(owed_results.size(), want);
      end
      pending_o = owed_results.size();
    end
  end

endmodule

// ----- tb/tb_scored_entry_max_extractor.sv -----
// Testbench top for the scored entry max extractor: clock, reset, command
// stimulus, receiver back-pressure, watchdog and verdict. Depends on sem_pkg,
// sem_extract_checker and the block itself.
`timescale 1ns / 1ps

module tb_scored_entry_max_extractor;
  import sem_pkg::*;

  localparam int unsigned Slots         = 256;
  // A pop on a full table scans all Slots entries; the limit leaves wide margin
  // for that plus long random stalls on either side.
  localparam int unsigned StallLimit    = 4000;
  localparam int unsigned DrainCycles   = 300;
  localparam int unsigned ItemsPerPhase = 650;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_ready;
  sem_cmd_e          cmd;
  logic [MoveW-1:0]  entry_move;
  logic [ScoreW-1:0] entry_score;
  logic              out_valid;
  logic              out_ready;
  logic              found;
  logic [MoveW-1:0]  top_move;
  logic [ScoreW-1:0] top_score;
  logic              overflow;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_checked;
  int unsigned entries_popped;
  int unsigned pushes_dropped;

  // Idle rates of the sender and the receiver, in percent of cycles.
  int unsigned send_gap_pct;
  int unsigned recv_gap_pct;
  int unsigned items_sent;
  int unsigned n_push, n_pop, n_clear, n_unused;
  int unsigned stall_cycles;

  scored_entry_max_extractor #(
    .CAPACITY(Slots)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .cmd_i        (cmd),
    .entry_move_i (entry_move),
    .entry_score_i(entry_score),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .found_o      (found),
    .top_move_o   (top_move),
    .top_score_o  (top_score),
    .overflow_o   (overflow)
  );

  sem_extract_checker #(
    .CAPACITY(Slots)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .cmd_i            (cmd),
    .entry_move_i     (entry_move),
    .entry_score_i    (entry_score),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .found_i          (found),
    .top_move_i       (top_move),
    .top_score_i      (top_score),
    .overflow_i       (overflow),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .results_checked_o(results_checked),
    .entries_popped_o (entries_popped),
    .pushes_dropped_o (pushes_dropped)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The receiver decides afresh at every edge whether it takes a result.
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
  end

  // Counts consecutive cycles in which neither channel completes a transfer.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= StallLimit);
    $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
             StallLimit, pending);
    $display("TB_ERROR");
    $finish;
  end

  // Scores lean toward the saturation code, the floor, the maximum and a
  // narrow band around zero so that ties are frequent; the rest are raw words.
  function automatic logic [ScoreW-1:0] pick_score();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      pick_score = ScoreMinCode;
    end else if (sel < 14) begin
      pick_score = ScoreFloor;
    end else if (sel < 20) begin
      pick_score = 32'h7FFF_FFFF;
    end else if (sel < 50) begin
      pick_score = $urandom_range(0, 6) - 3;
    end else begin
      pick_score = $urandom;
    end
  endfunction

  function automatic logic [MoveW-1:0] pick_move();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      pick_move = '0;
    end else if (sel == 1) begin
      pick_move = '1;
    end else begin
      pick_move = MoveW'($urandom_range(0, 65535));
    end
  endfunction

  // Offers one command and returns at the edge where its transfer completes.
  // When the sender takes a gap, valid drops at the current edge and rises
  // again no earlier than the next one, so a held valid is never toggled
  // within one time step.
  task automatic send_cmd(input sem_cmd_e op, input logic [MoveW-1:0] mv,
                          input logic [ScoreW-1:0] sc);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_valid    <= 1'b1;
    cmd         <= op;
    entry_move  <= mv;
    entry_score <= sc;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
    case (op)
      CMD_PUSH:  n_push++;
      CMD_POP:   n_pop++;
      CMD_CLEAR: n_clear++;
      default:   n_unused++;
    endcase
  endtask

  // Random traffic for one idling phase. Most of it is well-formed: a table is
  // filled with a handful of entries and drained past empty. Noise bursts mix
  // all four command codes with raw fields, tie bursts stack identical
  // extreme scores, and once per phase the table is filled to capacity so that
  // full-table pops and dropped pushes are exercised.
  task automatic run_random(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned fill_at;
    int unsigned kind;
    int unsigned depth;
    bit          filled;
    stop_at = items_sent + n_items;
    fill_at = items_sent + $urandom_range(n_items / 4, n_items / 2);
    filled  = 1'b0;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (!filled && items_sent >= fill_at) begin
        filled = 1'b1;
        send_cmd(CMD_CLEAR, pick_move(), pick_score());
        repeat (Slots) send_cmd(CMD_PUSH, pick_move(), pick_score());
        // The table is full now: these three are dropped and flagged.
        send_cmd(CMD_PUSH, '1, ScoreMinCode);
        repeat (2) send_cmd(CMD_PUSH, pick_move(), pick_score());
        repeat (4) send_cmd(CMD_POP, pick_move(), pick_score());
        // Four pushes refill the freed slots, the fifth overflows again.
        repeat (5) send_cmd(CMD_PUSH, pick_move(), pick_score());
        repeat (3) send_cmd(CMD_POP, pick_move(), pick_score());
        send_cmd(CMD_CLEAR, pick_move(), pick_score());
      end else if (kind < 65) begin
        if ($urandom_range(0, 9) != 0) send_cmd(CMD_CLEAR, pick_move(), pick_score());
        depth = $urandom_range(1, 12);
        repeat (depth) send_cmd(CMD_PUSH, pick_move(), pick_score());
        repeat ($urandom_range(0, 6)) begin
          send_cmd(($urandom_range(0, 2) == 0) ? CMD_PUSH : CMD_POP, pick_move(), pick_score());
        end
        repeat (depth + 2) send_cmd(CMD_POP, pick_move(), pick_score());
      end else if (kind < 85) begin
        repeat (8) begin
          send_cmd(sem_cmd_e'($urandom_range(0, 3)), MoveW'($urandom_range(0, 65535)),
                   $urandom);
        end
      end else begin
        repeat (6) begin
          case ($urandom_range(0, 3))
            0:       send_cmd(CMD_PUSH, pick_move(), ScoreMinCode);
            1:       send_cmd(CMD_PUSH, pick_move(), ScoreFloor);
            2:       send_cmd(CMD_PUSH, pick_move(), '0);
            default: send_cmd(CMD_PUSH, pick_move(), 32'h7FFF_FFFF);
          endcase
        end
        repeat (7) send_cmd(CMD_POP, pick_move(), pick_score());
      end
    end
  endtask

  initial begin : stimulus
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    cmd          = CMD_NONE;
    entry_move   = '0;
    entry_score  = '0;
    out_ready    = 1'b0;
    send_gap_pct = 21;
    recv_gap_pct = 62;
    items_sent   = 0;
    stall_cycles = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening. A pop on an empty table comes first.
    send_cmd(CMD_POP, '1, '1);
    // The most negative code must be stored as the floor value.
    send_cmd(CMD_PUSH, 16'h0000, ScoreMinCode);
    send_cmd(CMD_PUSH, 16'hFFFF, 32'h7FFF_FFFF);
    send_cmd(CMD_PUSH, 16'h1234, ScoreFloor);
    // A later entry with the same top score must lose to the earlier one.
    send_cmd(CMD_PUSH, 16'hAAAA, 32'h7FFF_FFFF);
    send_cmd(CMD_POP, '0, '0);
    send_cmd(CMD_POP, '0, '0);
    // Two entries at the floor remain; the earlier slot goes first.
    send_cmd(CMD_POP, '0, '0);
    send_cmd(CMD_POP, '0, '0);
    send_cmd(CMD_POP, '0, '0);
    // The unused code must leave the table alone, empty or not.
    send_cmd(CMD_NONE, 16'h5555, 32'h5555_5555);
    send_cmd(CMD_PUSH, 16'h0001, 32'hFFFF_FFFF);
    send_cmd(CMD_PUSH, 16'h0002, 32'h0000_0000);
    send_cmd(CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_POP, '0, '0);
    send_cmd(CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_POP, '0, '0);
    send_cmd(CMD_PUSH, 16'h7FFF, 32'h0000_0001);
    send_cmd(CMD_CLEAR, 16'h0000, 32'h0000_0000);
    send_cmd(CMD_PUSH, 16'h8000, 32'h8000_0002);
    send_cmd(CMD_POP, '0, '0);
    send_cmd(CMD_POP, '0, '0);

    run_random(ItemsPerPhase);
    send_gap_pct = 62;
    recv_gap_pct = 21;
    run_random(ItemsPerPhase);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    run_random(ItemsPerPhase);
    in_valid <= 1'b0;

    // Every command yields one result; wait for the last ones, then give the
    // block time to show any stray result before the verdict.
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d pushes, %0d pops, %0d clears and %0d unused commands;",
             n_push, n_pop, n_clear, n_unused);
    $display("%0d results checked, %0d pops returned an entry, %0d pushes hit a full table.",
             results_checked, entries_popped, pushes_dropped);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- scored_entry_max_extractor.f -----
rtl/core/sem_pkg.sv
rtl/core/sem_ctrl.sv
rtl/core/sem_dp.sv
rtl/core/scored_entry_max_extractor.sv
tb/sem_extract_checker.sv
tb/tb_scored_entry_max_extractor.sv
